// ----- design/rrqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrqs_pkg: shared types and constants of the round-robin quantum scheduler
// Operation codes, task status codes, beat payload structs and defaults.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    localparam int NUM_TASKS_DEF  = 16;
    localparam int IDLE_INDEX_DEF = 0;
    localparam int TASK_REQ_W     = 4;
    localparam int QUANTUM_W      = 16;

    localparam logic [QUANTUM_W-1:0] DEFAULT_QUANTUM_RST = 16'd10;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READY = 2'd1,
        FUNC_BLOCK = 2'd2,
        FUNC_SET_Q = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TS_FREE    = 2'd0,
        TS_QUEUED  = 2'd1,
        TS_RUN     = 2'd2,
        TS_PARKED  = 2'd3
    } t_status;

    typedef struct packed {
        t_func                 func;
        logic [TASK_REQ_W-1:0] task_req;
        logic [QUANTUM_W-1:0]  quantum;
    } t_sched_in;

    typedef struct packed {
        logic                  switched;
        logic [TASK_REQ_W-1:0] running;
        logic [QUANTUM_W-1:0]  remaining;
        logic                  ready_empty;
        logic                  error;
    } t_sched_out;

endpackage

// ----- design/rrqs_in_stage.sv -----
// ----------------------------------------------------------------------------
// rrqs_in_stage: input register
// Capture one request beat and hold it until the core takes it.
// ----------------------------------------------------------------------------
module rrqs_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rrqs_pkg::t_sched_in   i_data,
    output logic                  o_stall,
    input  logic                  i_take,
    output logic                  o_valid,
    output rrqs_pkg::t_sched_in   o_data
);
    import rrqs_pkg::*;

    logic      r_valid;
    t_sched_in r_data;

    // Hold while a captured beat has not been taken yet.
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- design/rrqs_core.sv -----
// ----------------------------------------------------------------------------
// rrqs_core: scheduler state and single-pass update
// Ready queue, task status and quantum tables, running task and tick counter.
// ----------------------------------------------------------------------------
module rrqs_core #(
    parameter int NUM_TASKS  = rrqs_pkg::NUM_TASKS_DEF,
    parameter int IDLE_INDEX = rrqs_pkg::IDLE_INDEX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrqs_pkg::QUANTUM_W-1:0]    i_cfg_data,
    input  logic                              i_step,
    input  rrqs_pkg::t_sched_in               i_item,
    output rrqs_pkg::t_sched_out              o_result
);
    import rrqs_pkg::*;

    localparam int TASK_W = $clog2(NUM_TASKS);
    localparam int CNT_W  = $clog2(NUM_TASKS + 1);
    localparam bit IDLE_IN_TABLE = (IDLE_INDEX < NUM_TASKS);
    localparam bit RESET_IDLE    = (IDLE_INDEX == 1);
    localparam logic [TASK_W-1:0]     IDLE_T   = TASK_W'(IDLE_INDEX % NUM_TASKS);
    localparam logic [TASK_W-1:0]     LAST_T   = TASK_W'(NUM_TASKS - 1);
    localparam logic [TASK_W-1:0]     RESET_T  = TASK_W'(1);
    localparam logic [TASK_REQ_W-1:0] IDLE_OUT = TASK_REQ_W'(IDLE_INDEX);

    logic [QUANTUM_W-1:0] r_def_q;
    logic [TASK_W-1:0]    r_fifo [NUM_TASKS];
    logic [TASK_W-1:0]    r_head;
    logic [TASK_W-1:0]    r_tail;
    logic [CNT_W-1:0]     r_count;
    t_status              r_status [NUM_TASKS];
    logic [QUANTUM_W-1:0] r_q_tab [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_q_set;
    logic [TASK_W-1:0]    r_run_task;
    logic                 r_run_idle;
    logic [QUANTUM_W-1:0] r_run_q;
    logic [QUANTUM_W-1:0] r_tick;

    logic [TASK_W-1:0]    n_head;
    logic [TASK_W-1:0]    n_tail;
    logic [CNT_W-1:0]     n_count;
    logic [TASK_W-1:0]    n_run_task;
    logic                 n_run_idle;
    logic [QUANTUM_W-1:0] n_run_q;
    logic [QUANTUM_W-1:0] n_tick;

    logic [TASK_W-1:0]    req_idx;
    logic                 req_in_range;
    logic                 req_is_idle;
    logic                 run_is_req;
    t_status              req_status;
    logic                 q_empty;
    logic [TASK_W-1:0]    head_task;
    logic [QUANTUM_W-1:0] head_q;
    logic [QUANTUM_W-1:0] idle_q;
    logic [QUANTUM_W-1:0] tick_dec;

    logic                 do_switch;
    logic                 do_push;
    logic                 do_pop;
    logic                 mark_ready;
    logic                 set_q;
    logic                 err;
    logic [TASK_W-1:0]    push_task;
    t_status              old_st;

    always_comb begin
        req_idx      = TASK_W'(i_item.task_req);
        req_in_range = 32'(i_item.task_req) < 32'(NUM_TASKS);
        req_is_idle  = 32'(i_item.task_req) == 32'(IDLE_INDEX);
        run_is_req   = r_run_idle ? req_is_idle
                                  : (32'(r_run_task) == 32'(i_item.task_req));
        req_status   = r_status[req_idx];
        q_empty      = (r_count == '0);
        head_task    = r_fifo[r_head];
        head_q       = r_q_set[head_task] ? r_q_tab[head_task] : r_def_q;
        idle_q       = r_def_q;
        if (IDLE_IN_TABLE && r_q_set[IDLE_T]) begin
            idle_q = r_q_tab[IDLE_T];
        end
        tick_dec     = (r_tick == '0) ? '0 : r_tick - 1'b1;

        do_switch  = 1'b0;
        do_push    = 1'b0;
        mark_ready = 1'b0;
        set_q      = 1'b0;
        err        = 1'b0;
        push_task  = req_idx;
        old_st     = TS_PARKED;
        n_tick     = r_tick;
        n_run_q    = r_run_q;

        case (i_item.func)
            FUNC_TICK: begin
                n_tick = tick_dec;
                if (tick_dec == '0) begin
                    n_tick = r_run_q;
                    if (!q_empty) begin
                        do_switch = 1'b1;
                        // Preempt: requeue the running task unless idle.
                        if (!r_run_idle) begin
                            do_push   = 1'b1;
                            push_task = r_run_task;
                            old_st    = TS_QUEUED;
                        end
                    end
                end
            end
            FUNC_READY: begin
                if (!req_in_range || req_is_idle ||
                    req_status == TS_QUEUED || req_status == TS_RUN) begin
                    err = 1'b1;
                end else begin
                    mark_ready = 1'b1;
                    do_push    = 1'b1;
                end
            end
            FUNC_BLOCK: begin
                if (r_run_idle) begin
                    err = 1'b1;
                end else begin
                    do_switch = 1'b1;
                end
            end
            FUNC_SET_Q: begin
                if (!req_in_range) begin
                    err = 1'b1;
                end else begin
                    set_q = 1'b1;
                    if (run_is_req) begin
                        n_run_q = i_item.quantum;
                    end
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        do_pop     = do_switch && !q_empty;
        n_run_task = r_run_task;
        n_run_idle = r_run_idle;
        if (do_switch) begin
            if (q_empty) begin
                n_run_task = IDLE_T;
                n_run_idle = 1'b1;
                n_run_q    = idle_q;
            end else begin
                n_run_task = head_task;
                n_run_idle = 1'b0;
                n_run_q    = head_q;
            end
            n_tick = n_run_q;
        end

        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        n_tail  = r_tail;
        if (do_push) begin
            n_tail = (r_tail == LAST_T) ? '0 : r_tail + 1'b1;
        end
        n_head  = r_head;
        if (do_pop) begin
            n_head = (r_head == LAST_T) ? '0 : r_head + 1'b1;
        end

        o_result.switched    = do_switch;
        o_result.running     = n_run_idle ? IDLE_OUT : TASK_REQ_W'(n_run_task);
        o_result.remaining   = n_tick;
        o_result.ready_empty = (n_count == '0);
        o_result.error       = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_q    <= DEFAULT_QUANTUM_RST;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_q_set    <= '0;
            r_run_task <= RESET_T;
            r_run_idle <= RESET_IDLE;
            r_run_q    <= DEFAULT_QUANTUM_RST;
            r_tick     <= DEFAULT_QUANTUM_RST;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_status[i] <= (i == 1) ? TS_RUN : TS_FREE;
            end
        end else if (i_cfg_we) begin
            // Reload every quantum from the new default.
            r_def_q <= i_cfg_data;
            r_q_set <= '0;
            r_run_q <= i_cfg_data;
            r_tick  <= i_cfg_data;
        end else if (i_step) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_run_task <= n_run_task;
            r_run_idle <= n_run_idle;
            r_run_q    <= n_run_q;
            r_tick     <= n_tick;
            if (set_q) begin
                r_q_set[req_idx] <= 1'b1;
            end
            if (mark_ready) begin
                r_status[req_idx] <= TS_QUEUED;
            end
            if (do_switch && !r_run_idle) begin
                r_status[r_run_task] <= old_st;
            end
            if (do_pop) begin
                r_status[head_task] <= TS_RUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && do_push) begin
            r_fifo[r_tail] <= push_task;
        end
        if (i_step && set_q) begin
            r_q_tab[req_idx] <= i_item.quantum;
        end
    end

endmodule

// ----- design/rrqs_out_stage.sv -----
// ----------------------------------------------------------------------------
// rrqs_out_stage: result register
// Hold one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module rrqs_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rrqs_pkg::t_sched_out  i_data,
    output logic                  o_can_load,
    output logic                  o_valid,
    output rrqs_pkg::t_sched_out  o_data,
    input  logic                  i_stall
);
    import rrqs_pkg::*;

    logic       r_valid;
    t_sched_out r_data;

    assign o_can_load = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- design/round_robin_quantum_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top: round-robin scheduler with time quantum
// Takes tick / make-ready / block / set-quantum requests, one result each.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                     payload
//   request   in         i_in_valid / o_in_stall       i_in_data  (t_sched_in)
//   result    out        o_out_valid / i_out_stall     o_out_data (t_sched_out)
//   config    in         i_cfg_we (no wait)            i_cfg_data (default quantum)
//
// One request beat per cycle while neither side stalls; each beat is held in the
// input register and is worked in a single pass of the core into the result
// register, from which it leaves while the result side does not stall.
// Reset is synchronous and active low: task 1 runs, queue empty, quanta at 10.
// A stall on the result side holds the result register and, through it, the
// input register; the request side stalls only while a held beat cannot move.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_top #(
    parameter int NUM_TASKS  = rrqs_pkg::NUM_TASKS_DEF,
    parameter int IDLE_INDEX = rrqs_pkg::IDLE_INDEX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  rrqs_pkg::t_sched_in             i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output rrqs_pkg::t_sched_out            o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [rrqs_pkg::QUANTUM_W-1:0]  i_cfg_data
);
    import rrqs_pkg::*;

    logic       held_valid;
    t_sched_in  held_item;
    logic       can_load;
    logic       take;
    t_sched_out result;

    // Advance the held beat whenever the result register has room.
    assign take = held_valid && can_load;

    rrqs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_valid (held_valid),
        .o_data  (held_item)
    );

    // Scheduler state steps once per taken beat, unless a config write in the same cycle wins.
    rrqs_core #(
        .NUM_TASKS  (NUM_TASKS),
        .IDLE_INDEX (IDLE_INDEX)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (take),
        .i_item     (held_item),
        .o_result   (result)
    );

    rrqs_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_data     (result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .i_stall    (i_out_stall)
    );

endmodule
